// ===== hw/rtl/secw_pkg.sv =====
// shared types and constants for the scanline edge crossing walker
// no dependencies
package secw_pkg;

  localparam int MAX_ROWS_DEF = 63;
  localparam int CNT_W = 6;
  localparam int DVD_W = 49;
  localparam int ACC_W = 48;

  localparam logic [31:0] SLOPE_60 = 32'h0001_4DA0;
  localparam logic [31:0] SLOPE_90 = 32'h0007_9883;
  localparam logic [31:0] SLOPE_75 = 32'h0002_6A0A;
  localparam logic [31:0] SLOPE_45 = 32'h0000_21B4;

  typedef enum logic [1:0] {
    DIR_UNKNOWN = 2'd0,
    DIR_POS     = 2'd1,
    DIR_NEG     = 2'd2,
    DIR_NONE    = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    LINK_ABOVE = 3'd0,
    LINK_BELOW = 3'd1,
    LINK_LEFT  = 3'd2,
    LINK_RIGHT = 3'd3,
    LINK_NONE  = 3'd4
  } link_t;

  typedef enum logic [1:0] {
    XL_NONE = 2'd0,
    XL_MIN  = 2'd1,
    XL_MAX  = 2'd2
  } xlist_t;

  localparam logic [2:0] SC_FLAT = 3'd0;
  localparam logic [2:0] SC_45   = 3'd1;
  localparam logic [2:0] SC_60   = 3'd2;
  localparam logic [2:0] SC_75   = 3'd3;
  localparam logic [2:0] SC_VERT = 3'd4;

  localparam logic KIND_CROSS = 1'b0;
  localparam logic KIND_EXTRA = 1'b1;

  localparam logic CFG_ALL_POINTS = 1'b0;
  localparam logic CFG_OFFSET     = 1'b1;

  typedef struct packed {
    logic capture;
    logic analyze;
    logic div_step;
    logic mul;
    logic round;
    logic load;
    logic emit_extra;
    logic emit_cross;
  } secw_cmd_t;

  typedef struct packed {
    logic begin_path;
    logic extra;
    logic has_cross;
    logic div_done;
    logic cross_last;
  } secw_stat_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [2:0]  slope;
    logic [2:0]  link;
    logic [1:0]  xl;
    logic        ovf;
    logic        last;
  } secw_rec_t;

endpackage

// ===== hw/rtl/scanline_edge_crossing_walker_core.sv =====
// top level of the scanline edge crossing walker
// depends on secw_pkg, secw_ctrl, secw_dp
//
// input channel: in_valid/in_ready with action, point_x, point_y (16.16)
// output channel: out_valid/out_ready with one record per transfer
// config channel: cfg_valid/cfg_ready, cfg_index 0 all_points, 1 offset_center
// one item is in flight at a time; in_ready is high only while idle
// a path begin is captured and analysed and gives no record
// an added point is captured and analysed, may give an extra-point record,
// then runs the bit-serial slope divider, then the multiply, round and start
// x load steps, then gives one record per midline crossing (at most MAX_ROWS)
// the last record of an item carries last=1
// records sit in an output register; a stalled receiver holds the walker
// in its emit step until the register drains
// reset clears path state, directions and both config registers
module scanline_edge_crossing_walker_core import secw_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic signed [31:0] cross_x,
  output logic signed [31:0] cross_y,
  output logic [2:0]         slope_class,
  output logic [2:0]         link,
  output logic [1:0]         x_list,
  output logic               overflow,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic               cfg_data
);

  logic       all_points, offset_center;
  logic       slot_free;
  secw_cmd_t  cmd;
  secw_stat_t stat;
  secw_rec_t  rec;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      all_points <= 1'b0;
      offset_center <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ALL_POINTS: all_points <= cfg_data;
        CFG_OFFSET:     offset_center <= cfg_data;
        default: ;
      endcase
    end
  end

  secw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .slot_free (slot_free),
    .stat      (stat),
    .cmd       (cmd)
  );

  secw_dp #(.MAX_ROWS(MAX_ROWS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .all_points    (all_points),
    .offset_center (offset_center),
    .action        (action),
    .point_x       (point_x),
    .point_y       (point_y),
    .rec           (rec)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit_extra || cmd.emit_cross) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.emit_extra || cmd.emit_cross) begin
      kind <= rec.kind;
      cross_x <= rec.x;
      cross_y <= rec.y;
      slope_class <= rec.slope;
      link <= rec.link;
      x_list <= rec.xl;
      overflow <= rec.ovf;
      last <= rec.last;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");

  a_extra_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EXTRA |-> slope_class == SC_FLAT && link == LINK_NONE)
    else $error("extra-point record with crossing fields");

  a_cross_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_CROSS |-> x_list == XL_NONE)
    else $error("crossing record with x list tag");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(cmd.emit_extra || cmd.emit_cross))
    else $error("record emitted while idle");

endmodule

// ===== hw/rtl/secw_ctrl.sv =====
// controller state machine for the scanline edge crossing walker
// depends on secw_pkg
module secw_ctrl import secw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       slot_free,
  input  secw_stat_t stat,
  output secw_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_ANLZ  = 8'b00000010,
    ST_EXTRA = 8'b00000100,
    ST_DIV   = 8'b00001000,
    ST_MUL   = 8'b00010000,
    ST_ROUND = 8'b00100000,
    ST_LOAD  = 8'b01000000,
    ST_CROSS = 8'b10000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = ST_ANLZ;
      end
      ST_ANLZ: begin
        cmd.analyze = 1'b1;
        if (stat.begin_path) state_next = ST_IDLE;
        else if (stat.extra) state_next = ST_EXTRA;
        else if (stat.has_cross) state_next = ST_DIV;
        else state_next = ST_IDLE;
      end
      ST_EXTRA: begin
        if (slot_free) begin
          cmd.emit_extra = 1'b1;
          state_next = stat.has_cross ? ST_DIV : ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        state_next = ST_CROSS;
      end
      ST_CROSS: begin
        if (slot_free) begin
          cmd.emit_cross = 1'b1;
          if (stat.cross_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

endmodule

// ===== hw/rtl/secw_dp.sv =====
// datapath: path state, serial divider, slope multiply, crossing stepper
// depends on secw_pkg
module secw_dp import secw_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  secw_cmd_t          cmd,
  output secw_stat_t         stat,
  input  logic               all_points,
  input  logic               offset_center,
  input  logic               action,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  output secw_rec_t          rec
);

  localparam logic [CNT_W-1:0] MAXR = CNT_W'(MAX_ROWS);
  localparam logic [5:0] DIV_LAST = 6'(DVD_W - 1);

  logic               act_r;
  logic signed [31:0] ex, ey;
  logic signed [31:0] prev_x, prev_y, seg_x, seg_y;
  dir_t               horiz_dir, vert_dir;
  logic signed [31:0] last_cross_x, last_cross_y;
  logic               have_last_cross;

  logic               extra_r, has_cross, up_r, ovf_r, neg_r, first;
  logic [1:0]         xl_r;
  logic signed [31:0] ym;
  logic [CNT_W-1:0]   cnt;
  logic [32:0]        ud;
  logic [32:0]        rem;
  logic [DVD_W-1:0]   dvd;
  logic [5:0]         dcnt;
  logic [16:0]        mdist;
  logic signed [31:0] xd;
  logic [DVD_W-1:0]   prod;
  logic signed [ACC_W-1:0] cx;
  logic [2:0]         sc;

  // analysis of the new segment
  logic signed [31:0] ny;
  dir_t               hd_next, vd_next;
  logic               hchg, vchg, up, hit, ovf;
  logic [1:0]         xl;
  logic signed [33:0] base, ym0, dym;
  logic signed [34:0] diff;
  logic [18:0]        rows;
  logic signed [32:0] dx, dy;
  logic [32:0]        un, udn;

  assign ny = (point_y[15:0] == 16'h8000) ? point_y + 32'sd1 : point_y;

  always_comb begin
    hd_next = horiz_dir;
    hchg = 1'b0;
    xl = XL_NONE;
    if (seg_sx_lt()) begin
      if (horiz_dir != DIR_POS) begin hchg = 1'b1; xl = XL_MIN; hd_next = DIR_POS; end
    end else if (prev_x == ex) begin
      if (horiz_dir != DIR_NONE) begin
        hchg = 1'b1;
        xl = (horiz_dir == DIR_NEG) ? XL_MIN : XL_MAX;
        hd_next = DIR_NONE;
      end
    end else if (horiz_dir != DIR_NEG) begin
      hchg = 1'b1; xl = XL_MAX; hd_next = DIR_NEG;
    end
    if (prev_y < ey) vd_next = DIR_POS;
    else if (prev_y == ey) vd_next = DIR_NONE;
    else vd_next = DIR_NEG;
    vchg = (vd_next != vert_dir);
    up = prev_y < ey;
    base = up ? (34'(prev_y) + 34'sh8000) : (34'(prev_y) - 34'sh8000);
    ym0 = {base[33:16], 16'h8000};
    diff = up ? (35'(ey) - 35'(ym0)) : (35'(ym0) - 35'(ey));
    hit = !diff[34] && (prev_y != ey);
    rows = diff[34:16];
    ovf = hit && (rows >= 19'(MAX_ROWS));
    dx = 33'(ex) - 33'(prev_x);
    dy = 33'(ey) - 33'(prev_y);
    un = dx[32] ? 33'(-dx) : 33'(dx);
    udn = dy[32] ? 33'(-dy) : 33'(dy);
    dym = ym0 - 34'(prev_y);
  end

  function automatic logic seg_sx_lt();
    return prev_x < ex;
  endfunction

  // divider step
  logic [33:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign ge = rem_sh >= {1'b0, ud};

  // saturated quotient
  logic signed [31:0] xd_q;
  always_comb begin
    if (!neg_r) xd_q = (dvd > DVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : dvd[31:0];
    else xd_q = (dvd > DVD_W'(32'h8000_0000)) ? 32'sh8000_0000 : -dvd[31:0];
  end

  logic [31:0] axd;
  assign axd = xd[31] ? 32'(-xd) : 32'(xd);

  logic [33:0] rnd;
  logic        mneg;
  assign rnd = 34'((prod + DVD_W'(16'h8000)) >> 16);
  assign mneg = xd[31] ^ !up_r;

  // crossing output
  logic signed [31:0] ox;
  logic [2:0]         lk;
  always_comb begin
    if (cx > ACC_W'(32'sh7FFF_FFFF)) ox = 32'sh7FFF_FFFF;
    else if (cx < -ACC_W'(33'sh8000_0000)) ox = 32'sh8000_0000;
    else ox = cx[31:0];
    if (!first) lk = up_r ? LINK_ABOVE : LINK_BELOW;
    else if (!have_last_cross) lk = LINK_NONE;
    else if (ym > last_cross_y) lk = LINK_ABOVE;
    else if (ym < last_cross_y) lk = LINK_BELOW;
    else lk = (ox < last_cross_x) ? LINK_LEFT : LINK_RIGHT;
  end

  always_comb begin
    rec.ovf = ovf_r;
    if (cmd.emit_extra) begin
      rec.kind = KIND_EXTRA;
      rec.x = seg_x;
      rec.y = seg_y;
      rec.slope = SC_FLAT;
      rec.link = LINK_NONE;
      rec.xl = xl_r;
      rec.last = !has_cross;
    end else begin
      rec.kind = KIND_CROSS;
      rec.x = ox;
      rec.y = ym;
      rec.slope = sc;
      rec.link = lk;
      rec.xl = XL_NONE;
      rec.last = (cnt == CNT_W'(1));
    end
  end

  assign stat.begin_path = !act_r;
  assign stat.extra = all_points || hchg || vchg;
  assign stat.has_cross = cmd.analyze ? hit : has_cross;
  assign stat.div_done = (dcnt == DIV_LAST);
  assign stat.cross_last = (cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
      horiz_dir <= DIR_UNKNOWN;
      vert_dir <= DIR_UNKNOWN;
      last_cross_x <= '0;
      last_cross_y <= '0;
      have_last_cross <= 1'b0;
      has_cross <= 1'b0;
    end else begin
      if (cmd.capture) begin
        act_r <= action;
        ex <= point_x;
        ey <= ny;
      end
      if (cmd.analyze) begin
        prev_x <= ex;
        prev_y <= ey;
        seg_x <= prev_x;
        seg_y <= prev_y;
        if (!act_r) begin
          horiz_dir <= DIR_UNKNOWN;
          vert_dir <= DIR_UNKNOWN;
          have_last_cross <= 1'b0;
          has_cross <= 1'b0;
        end else begin
          horiz_dir <= hd_next;
          vert_dir <= vd_next;
          has_cross <= hit;
        end
        xl_r <= xl;
        up_r <= up;
        ym <= ym0[31:0];
        ovf_r <= ovf;
        cnt <= ovf ? MAXR : CNT_W'(rows) + CNT_W'(1);
        neg_r <= dx[32] ^ dy[32];
        ud <= udn;
        rem <= '0;
        dvd <= {un, 16'h0000};
        dcnt <= '0;
        mdist <= dym[33] ? 17'(-dym) : 17'(dym);
        first <= 1'b1;
      end
      if (cmd.div_step) begin
        rem <= ge ? 33'(rem_sh - {1'b0, ud}) : rem_sh[32:0];
        dvd <= {dvd[DVD_W-2:0], ge};
        dcnt <= dcnt + 6'd1;
      end
      if (cmd.mul) begin
        xd <= xd_q;
      end
      if (cmd.round) begin
        prod <= DVD_W'(axd) * DVD_W'(mdist);
      end
      if (cmd.load) begin
        cx <= ACC_W'(seg_x) + (mneg ? -ACC_W'(rnd) : ACC_W'(rnd));
      end
      if (cmd.emit_cross) begin
        last_cross_x <= ox;
        last_cross_y <= ym;
        have_last_cross <= 1'b1;
        first <= 1'b0;
        cnt <= cnt - CNT_W'(1);
        ym <= up_r ? ym + 32'sh0001_0000 : ym - 32'sh0001_0000;
        cx <= up_r ? cx + ACC_W'(xd) : cx - ACC_W'(xd);
      end
      if (cmd.mul) begin
        if (!offset_center) sc <= SC_FLAT;
        else sc <= slope_of(xd_q);
      end
    end
  end

  function automatic logic [2:0] slope_of(input logic signed [31:0] v);
    logic [31:0] t;
    t = v[31] ? 32'(-v) : 32'(v);
    if (t >= SLOPE_60) begin
      if (t >= SLOPE_90) return SC_VERT;
      if (t >= SLOPE_75) return SC_75;
      return SC_60;
    end
    return (t <= SLOPE_45) ? SC_FLAT : SC_45;
  endfunction

endmodule

// ===== dv/secw_checker.sv =====
// checker for the scanline edge crossing walker: watches the input, output and
// config channels, predicts every record and compares it with the block output
// depends on secw_pkg
module secw_checker import secw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        action,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        kind,
  input  logic [31:0] cross_x,
  input  logic [31:0] cross_y,
  input  logic [2:0]  slope_class,
  input  logic [2:0]  link,
  input  logic [1:0]  x_list,
  input  logic        overflow,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data,
  output int          pending,
  output int          errors
);

  localparam longint ROW = 65536;
  localparam longint HALF = 32768;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic   emit_all, slope_on;
  longint pen_x, pen_y, prev_cx, prev_cy;
  dir_t   hdir, vdir;
  logic   prev_c_ok;
  secw_rec_t expected_recs[$];

  assign pending = expected_recs.size();

  function automatic longint sext(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint mid_nudge(longint y);
    return (y & 64'hFFFF) == HALF ? y + 1 : y;
  endfunction

  function automatic longint midline_below(longint v);
    longint q;
    q = v >= 0 ? v / ROW : -((-v + ROW - 1) / ROW);
    return q * ROW + HALF;
  endfunction

  function automatic longint slope_div(longint n, longint d);
    logic neg;
    longint unsigned un, ud, q;
    neg = (n < 0) != (d < 0);
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    if (ud == 0) return 0;
    q = (un << 16) / ud;
    if (!neg) return q > 64'h7FFFFFFF ? S32_MAX : longint'(q);
    if (q > 64'h80000000) return S32_MIN;
    return -longint'(q);
  endfunction

  function automatic longint scaled_mul(longint a, longint b);
    logic neg;
    longint unsigned p;
    longint r;
    neg = (a < 0) != (b < 0);
    p = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
    r = longint'((p + 64'h8000) >> 16);
    return neg ? -r : r;
  endfunction

  function automatic logic [2:0] slope_bin(longint xd);
    longint t;
    t = xd < 0 ? -xd : xd;
    if (t >= longint'({32'b0, SLOPE_60})) begin
      if (t >= longint'({32'b0, SLOPE_90})) return SC_VERT;
      if (t >= longint'({32'b0, SLOPE_75})) return SC_75;
      return SC_60;
    end
    return t <= longint'({32'b0, SLOPE_45}) ? SC_FLAT : SC_45;
  endfunction

  task automatic walk_point(logic act, logic [31:0] px, logic [31:0] py);
    longint sx, sy, ex, ey, ym, xd, cx, ox;
    logic extra, up, ovf;
    xlist_t xl;
    logic [2:0] sc;
    link_t lk;
    int n, k;
    secw_rec_t recs[$];
    secw_rec_t r;
    sx = pen_x;
    sy = mid_nudge(pen_y);
    ex = sext(px);
    ey = mid_nudge(sext(py));
    extra = emit_all;
    ovf = 1'b0;
    xl = XL_NONE;
    k = 0;
    if (!act) begin
      pen_x = ex;
      pen_y = ey;
      hdir = DIR_UNKNOWN;
      vdir = DIR_UNKNOWN;
      prev_c_ok = 1'b0;
      return;
    end
    if (sx < ex) begin
      if (hdir != DIR_POS) begin
        extra = 1'b1; xl = XL_MIN; hdir = DIR_POS;
      end
    end else if (sx == ex) begin
      if (hdir != DIR_NONE) begin
        extra = 1'b1;
        if (hdir == DIR_NEG) xl = XL_MIN;
        else xl = XL_MAX;
        hdir = DIR_NONE;
      end
    end else if (hdir != DIR_NEG) begin
      extra = 1'b1; xl = XL_MAX; hdir = DIR_NEG;
    end
    if (sy < ey) begin
      if (vdir != DIR_POS) extra = 1'b1;
      vdir = DIR_POS;
    end else if (sy == ey) begin
      if (vdir != DIR_NONE) extra = 1'b1;
      vdir = DIR_NONE;
    end else begin
      if (vdir != DIR_NEG) extra = 1'b1;
      vdir = DIR_NEG;
    end
    if (extra) begin
      r = '0;
      r.kind = KIND_EXTRA;
      r.x = sx[31:0];
      r.y = sy[31:0];
      r.slope = SC_FLAT;
      r.link = LINK_NONE;
      r.xl = xl;
      recs.push_back(r);
    end
    if (sy != ey) begin
      up = sy < ey;
      ym = midline_below(up ? sy + HALF : sy - HALF);
      if (up ? ym <= ey : ym >= ey) begin
        xd = slope_div(ex - sx, ey - sy);
        cx = sx + scaled_mul(xd, ym - sy);
        sc = slope_on ? slope_bin(xd) : SC_FLAT;
        while (up ? ym <= ey : ym >= ey) begin
          ox = clamp32(cx);
          if (k >= MAX_ROWS_DEF) begin
            ovf = 1'b1;
            break;
          end
          if (k != 0) begin
            if (up) lk = LINK_ABOVE;
            else lk = LINK_BELOW;
          end
          else if (!prev_c_ok) lk = LINK_NONE;
          else if (ym > prev_cy) lk = LINK_ABOVE;
          else if (ym < prev_cy) lk = LINK_BELOW;
          else if (ox < prev_cx) lk = LINK_LEFT;
          else lk = LINK_RIGHT;
          r = '0;
          r.kind = KIND_CROSS;
          r.x = ox[31:0];
          r.y = ym[31:0];
          r.slope = sc;
          r.link = lk;
          r.xl = XL_NONE;
          recs.push_back(r);
          prev_cx = ox;
          prev_cy = ym;
          prev_c_ok = 1'b1;
          k++;
          if (up) begin
            ym += ROW; cx += xd;
          end else begin
            ym -= ROW; cx -= xd;
          end
        end
      end
    end
    pen_x = ex;
    pen_y = ey;
    n = recs.size();
    for (int i = 0; i < n; i++) begin
      r = recs[i];
      r.ovf = ovf;
      r.last = i == n - 1;
      expected_recs.push_back(r);
    end
  endtask

  task automatic field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    secw_rec_t e;
    if (rst) begin
      emit_all <= 1'b0;
      slope_on <= 1'b0;
      pen_x = 0;
      pen_y = 0;
      hdir = DIR_UNKNOWN;
      vdir = DIR_UNKNOWN;
      prev_cx = 0;
      prev_cy = 0;
      prev_c_ok = 1'b0;
      expected_recs.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ALL_POINTS) emit_all <= cfg_data;
        else slope_on <= cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_recs.size() == 0) begin
          $error("record transfer with nothing expected");
          errors++;
        end else begin
          e = expected_recs.pop_front();
          field_check("kind", 32'(e.kind), 32'(kind));
          field_check("cross_x", e.x, cross_x);
          field_check("cross_y", e.y, cross_y);
          field_check("slope_class", 32'(e.slope), 32'(slope_class));
          field_check("link", 32'(e.link), 32'(link));
          field_check("x_list", 32'(e.xl), 32'(x_list));
          field_check("overflow", 32'(e.ovf), 32'(overflow));
          field_check("last", 32'(e.last), 32'(last));
        end
      end
      if (in_valid && in_ready) walk_point(action, point_x, point_y);
    end
  end

endmodule

// ===== dv/tb.sv =====
// testbench top for scanline_edge_crossing_walker_core: drives path points and
// config writes with random gaps and output stalls, and gives the verdict
// depends on secw_pkg, secw_checker and the walker rtl
module tb;
  import secw_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [31:0] point_x = '0;
  logic [31:0] point_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [31:0] cross_x, cross_y;
  logic [2:0]  slope_class, link;
  logic [1:0]  x_list;
  logic        overflow, last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic        cfg_data = 1'b0;
  int          pending, errors;
  int          cycles = 0;
  int          stall_left = 0;
  logic        no_idle = 1'b0;
  logic        stall_on = 1'b1;
  longint      pen_row = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scanline_edge_crossing_walker_core u_top (
    .clk, .rst, .in_valid, .in_ready, .action, .point_x, .point_y,
    .out_valid, .out_ready, .kind, .cross_x, .cross_y, .slope_class, .link,
    .x_list, .overflow, .last, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  secw_checker u_chk (
    .clk, .rst, .in_valid, .in_ready, .action, .point_x, .point_y,
    .out_valid, .out_ready, .kind, .cross_x, .cross_y, .slope_class, .link,
    .x_list, .overflow, .last, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .pending, .errors
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("[scanline_edge_crossing_walker_core] ERROR");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    int s;
    s = stall_left;
    if (out_valid && out_ready) s = stall_on ? $urandom_range(0, 17) : 0;
    else if (s > 0) s = s - 1;
    stall_left <= s;
    out_ready <= s == 0;
  end

  function automatic int idle_draw();
    if (no_idle) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic send_point(logic act, logic [31:0] x, logic [31:0] y);
    int gap;
    action <= act;
    point_x <= x;
    point_y <= y;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly points near the current row, with half-row, flat,
  // vertical and full-range points mixed in
  task automatic random_point();
    logic [31:0] x, y;
    int sel;
    sel = $urandom_range(0, 99);
    x = $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    pen_row = pen_row + $signed($urandom_range(0, 24)) - 12;
    if (pen_row > 200 || pen_row < -200) pen_row = 0;
    y = 32'(pen_row * 65536 + $urandom_range(0, 65535));
    if (sel < 10) y[15:0] = 16'h8000;
    else if (sel < 15) y = point_y;
    else if (sel < 20) x = point_x;
    else if (sel < 24) y = $urandom;
    send_point(sel < 92 ? 1'b1 : 1'b0, x, y);
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, flats, verticals, half-row y, turns, overflow
    send_point(1'b1, 32'h0001_0000, 32'h0003_8000);
    send_point(1'b0, 32'h0000_0000, 32'h0000_0000);
    send_point(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(1'b1, 32'h8000_0000, 32'h8000_0000);
    send_point(1'b1, 32'h8000_0000, 32'h8000_0000);
    send_point(1'b0, 32'h0002_0000, 32'h0000_8000);
    send_point(1'b1, 32'h0002_0000, 32'h0004_8000);
    send_point(1'b1, 32'h0005_0000, 32'h0004_8000);
    send_point(1'b1, 32'h0001_0000, 32'h0001_0000);
    send_point(1'b1, 32'h0001_0000, 32'hFFFD_0000);
    send_point(1'b1, 32'h0001_4000, 32'hFFFD_4000);
    send_point(1'b1, 32'h7FFF_0000, 32'h0000_9000);
    send_point(1'b1, 32'h8001_0000, 32'h0000_7000);
    send_point(1'b1, 32'h0000_0000, 32'h0050_0000);
    send_point(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(1'b1, 32'h0000_0001, 32'h0003_0000);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_ALL_POINTS, ph[0]);
      write_reg(CFG_OFFSET, ph[1]);
      no_idle = ph == 2;
      stall_on = ph != 1;
      n = 40;
      send_point(1'b0, 32'h0, 32'h0);
      pen_row = 0;
      for (int i = 0; i < n; i++) begin
        random_point();
        // sender holds off until the block has drained
        if (i == 20) settle();
      end
      settle();
    end
    write_reg(CFG_ALL_POINTS, 1'b0);
    write_reg(CFG_OFFSET, 1'b0);
    for (int i = 0; i < 4; i++) random_point();
    settle();

    if (errors == 0) $display("[scanline_edge_crossing_walker_core] OK");
    else $display("[scanline_edge_crossing_walker_core] ERROR");
    $finish;
  end

endmodule
